FILE: rtl/rbst_pkg.sv
// Shared types for the ray against bounding sphere test pipeline.
`timescale 1ns / 1ps

package rbst_pkg;

  // Tag that travels alongside each word through the pipeline
  typedef struct packed {
    logic valid;    // stage holds a live word
    logic blocked;  // sphere lies behind the support and the support is outside
  } rbst_tag_t;

endpackage

FILE: rtl/rbst_wide_mul.sv
// Two-stage unsigned multiplier built from four narrower partial products.
`timescale 1ns / 1ps

module rbst_wide_mul #(
  parameter int WA = 33,
  parameter int LO = 17
) (
  input  logic              clk,
  input  logic              en,
  input  logic [WA-1:0]     a,
  input  logic [WA-1:0]     b,
  output logic [2*WA-1:0]   p
);

  localparam int HI = WA - LO;
  localparam int PW = 2 * WA;

  logic [2*LO-1:0]    pp_ll;
  logic [LO+HI-1:0]   pp_lh;
  logic [LO+HI-1:0]   pp_hl;
  logic [2*HI-1:0]    pp_hh;
  logic [PW-1:0]      p_next;

  // Stage one: partial products of the low and high halves
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a[LO-1:0]  * b[LO-1:0];
      pp_lh <= a[LO-1:0]  * b[WA-1:LO];
      pp_hl <= a[WA-1:LO] * b[LO-1:0];
      pp_hh <= a[WA-1:LO] * b[WA-1:LO];
    end
  end

  // Stage two: align and sum the partials
  always_comb begin
    p_next = (PW'(pp_hh) << (2 * LO))
           + ((PW'(pp_lh) + PW'(pp_hl)) << LO)
           + PW'(pp_ll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= p_next;
    end
  end

endmodule

FILE: rtl/rbst_front.sv
// Front stages: centre offset, component products, dot and cross sums, magnitudes.
`timescale 1ns / 1ps

module rbst_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] support_x,
  input  logic signed [COORD_WIDTH-1:0] support_y,
  input  logic signed [COORD_WIDTH-1:0] support_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  input  logic        [COORD_WIDTH-1:0] radius,
  output rbst_pkg::rbst_tag_t           tag,
  output logic [2*COORD_WIDTH:0]        cross_x,
  output logic [2*COORD_WIDTH:0]        cross_y,
  output logic [2*COORD_WIDTH:0]        cross_z,
  output logic [2*COORD_WIDTH:0]        dir_sq,
  output logic [2*COORD_WIDTH:0]        rad_sq
);

  import rbst_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;      // centre minus support
  localparam int PW = 2 * W + 2;  // products and their sums
  localparam int NW = 2 * W + 1;  // multiplier operands downstream

  // Stage 1 registers
  logic                 v1;
  logic signed [DW-1:0] off_x, off_y, off_z;
  logic signed [W-1:0]  d1_x, d1_y, d1_z;
  logic        [W-1:0]  r1;

  // Stage 2 registers
  logic                 v2;
  logic signed [PW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [PW-1:0] sq_x, sq_y, sq_z;
  logic signed [PW-1:0] ds_x, ds_y, ds_z;
  logic signed [PW-1:0] pr_x, pr_y, pr_z;
  logic        [2*W-1:0] r2_sq;

  // Stage 3 registers
  logic                 v3;
  logic signed [PW-1:0] cx, cy, cz;
  logic        [PW-1:0] dd_sum;
  logic        [PW-1:0] dir_sum;
  logic signed [PW-1:0] proj;
  logic        [2*W-1:0] r3_sq;

  // Stage 4 next values
  logic                 blocked_next;

  // Stage 1: offset of the centre from the support point
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_x <= DW'(center_x) - DW'(support_x);
      off_y <= DW'(center_y) - DW'(support_y);
      off_z <= DW'(center_z) - DW'(support_z);
      d1_x  <= dir_x;
      d1_y  <= dir_y;
      d1_z  <= dir_z;
      r1    <= radius;
    end
  end

  // Stage 2: all component products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_yz  <= off_y * d1_z;
      p_zy  <= off_z * d1_y;
      p_zx  <= off_z * d1_x;
      p_xz  <= off_x * d1_z;
      p_xy  <= off_x * d1_y;
      p_yx  <= off_y * d1_x;
      sq_x  <= off_x * off_x;
      sq_y  <= off_y * off_y;
      sq_z  <= off_z * off_z;
      ds_x  <= d1_x * d1_x;
      ds_y  <= d1_y * d1_y;
      ds_z  <= d1_z * d1_z;
      pr_x  <= off_x * d1_x;
      pr_y  <= off_y * d1_y;
      pr_z  <= off_z * d1_z;
      r2_sq <= r1 * r1;
    end
  end

  // Stage 3: cross product, squared lengths and projection
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx      <= p_yz - p_zy;
      cy      <= p_zx - p_xz;
      cz      <= p_xy - p_yx;
      dd_sum  <= $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
      dir_sum <= $unsigned(ds_x) + $unsigned(ds_y) + $unsigned(ds_z);
      proj    <= pr_x + pr_y + pr_z;
      r3_sq   <= r2_sq;
    end
  end

  // Stage 4: cross magnitudes, behind-and-outside flag
  // Sphere behind the support only counts when the support is not inside it.
  always_comb begin
    blocked_next = proj[PW-1] && (dd_sum >= PW'(r3_sq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (en) begin
      tag.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag.blocked <= blocked_next;
      cross_x     <= NW'(cx[PW-1] ? -cx : cx);
      cross_y     <= NW'(cy[PW-1] ? -cy : cy);
      cross_z     <= NW'(cz[PW-1] ? -cz : cz);
      dir_sq      <= NW'(dir_sum);
      rad_sq      <= NW'(r3_sq);
    end
  end

endmodule

FILE: rtl/ray_bounding_sphere_test_unit.sv
// Pipeline: 7 register stages from the accepted ray word to hit.
// Throughput: one ray word per unstalled cycle, set by the pipelined multipliers.
// A stalled hit word freezes every stage together; nothing is dropped or repeated.
// Reset (rst, synchronous, active high) clears every stage valid; data is not reset.
// Top level: ray against bounding sphere test, final squares and distance compare.
`timescale 1ns / 1ps

module ray_bounding_sphere_test_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ray_valid,
  output logic                          ray_stall,
  input  logic signed [COORD_WIDTH-1:0] support_x,
  input  logic signed [COORD_WIDTH-1:0] support_y,
  input  logic signed [COORD_WIDTH-1:0] support_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  input  logic        [COORD_WIDTH-1:0] radius,
  output logic                          hit_valid,
  input  logic                          hit_stall,
  output logic                          hit
);

  import rbst_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int NW  = 2 * W + 1;   // operand width of the wide multipliers
  localparam int QW  = 2 * NW;      // wide product width
  localparam int SW  = QW + 2;      // sum of three wide products

  logic       en;
  rbst_tag_t  tag4, tag5, tag6;
  logic [NW-1:0] cross_x, cross_y, cross_z, dir_sq, rad_sq;
  logic [QW-1:0] csq_x, csq_y, csq_z, rhs;
  logic [SW-1:0] lhs;
  logic          miss;
  logic          hit_next;

  // Whole pipeline moves unless a finished word is held at the output
  assign en        = !(hit_valid && hit_stall);
  assign ray_stall = !en;

  rbst_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ray_valid),
    .support_x (support_x),
    .support_y (support_y),
    .support_z (support_z),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .radius    (radius),
    .tag       (tag4),
    .cross_x   (cross_x),
    .cross_y   (cross_y),
    .cross_z   (cross_z),
    .dir_sq    (dir_sq),
    .rad_sq    (rad_sq)
  );

  // Squared cross product components give |D|^2*|d|^2 - (D.d)^2 exactly
  rbst_wide_mul #(.WA(NW), .LO(W + 1)) u_mul_x (
    .clk (clk), .en (en), .a (cross_x), .b (cross_x), .p (csq_x)
  );
  rbst_wide_mul #(.WA(NW), .LO(W + 1)) u_mul_y (
    .clk (clk), .en (en), .a (cross_y), .b (cross_y), .p (csq_y)
  );
  rbst_wide_mul #(.WA(NW), .LO(W + 1)) u_mul_z (
    .clk (clk), .en (en), .a (cross_z), .b (cross_z), .p (csq_z)
  );
  // r^2 * |d|^2
  rbst_wide_mul #(.WA(NW), .LO(W + 1)) u_mul_r (
    .clk (clk), .en (en), .a (rad_sq), .b (dir_sq), .p (rhs)
  );

  // Tags follow the two multiplier stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tag5.valid <= 1'b0;
      tag6.valid <= 1'b0;
    end else if (en) begin
      tag5.valid <= tag4.valid;
      tag6.valid <= tag5.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag5.blocked <= tag4.blocked;
      tag6.blocked <= tag5.blocked;
    end
  end

  // Final stage: distance test; equality (tangent) is not a miss
  always_comb begin
    lhs      = SW'(csq_x) + SW'(csq_y) + SW'(csq_z);
    miss     = SW'(rhs) < lhs;
    hit_next = !miss && !tag6.blocked;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (en) begin
      hit_valid <= tag6.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
    end
  end

endmodule

FILE: rtl/rbst_checker.sv
// Port-level checks for the ray against bounding sphere test unit, with bind.
`timescale 1ns / 1ps

module rbst_checker (
  input logic clk,
  input logic rst,
  input logic ray_valid,
  input logic ray_stall,
  input logic hit_valid,
  input logic hit_stall,
  input logic hit
);

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !hit_valid)
    else $error("hit word valid after reset");

  // Input is held off exactly when a finished word waits at the output
  a_stall_link: assert property (@(posedge clk)
    disable iff (rst) ray_stall == (hit_valid && hit_stall))
    else $error("ray stall does not follow output backpressure");

  // A stalled hit word stays put
  a_hold: assert property (@(posedge clk)
    disable iff (rst) (hit_valid && hit_stall) |=> (hit_valid && $stable(hit)))
    else $error("stalled hit word changed or dropped");

  // Without backpressure the input is never refused
  a_no_idle_stall: assert property (@(posedge clk)
    disable iff (rst) (ray_valid && !hit_stall) |-> !ray_stall)
    else $error("ray word refused with no output backpressure");

endmodule

bind ray_bounding_sphere_test_unit rbst_checker u_rbst_checker (
  .clk       (clk),
  .rst       (rst),
  .ray_valid (ray_valid),
  .ray_stall (ray_stall),
  .hit_valid (hit_valid),
  .hit_stall (hit_stall),
  .hit       (hit)
);
